// ===== rtl/scrc_pkg.sv =====
`timescale 1ns / 1ps

package scrc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SUMMER_DAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMER_NIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINTER_DAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINTER_NIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEASON_DATES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_HOURS    = 3'd5;

    localparam logic [39:0] SUMMER_DAY_RST   = 40'd112006537756;
    localparam logic [15:0] SUMMER_NIGHT_RST = 16'd8218;
    localparam logic [39:0] WINTER_DAY_RST   = 40'd94792850968;
    localparam logic [15:0] WINTER_NIGHT_RST = 16'd7190;
    localparam logic [17:0] SEASON_DATES_RST = 18'd141953;
    localparam logic [19:0] DAY_HOURS_RST    = 20'd664200;

    // spot lamp follows ambient limits inside this hour window
    localparam logic [4:0] SPOT_FIRST_HOUR = 5'd10;
    localparam logic [4:0] SPOT_LAST_HOUR  = 5'd16;

    typedef struct packed {
        logic [39:0] summer_day_limits;
        logic [15:0] summer_night_limits;
        logic [39:0] winter_day_limits;
        logic [15:0] winter_night_limits;
        logic [17:0] season_start_dates;
        logic [19:0] day_night_hours;
    } cfg_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [7:0] hot_zone_temp;
        logic [7:0] cold_zone_temp;
        logic [7:0] ambient_temp;
        logic       emergency_cut;
    } sensor_t;

    typedef struct packed {
        logic heater;
        logic spot;
        logic uv;
        logic vent;
    } latch_t;

    typedef struct packed {
        logic heater_on;
        logic spot_on;
        logic uv_on;
        logic vent_on;
        logic winter_active;
        logic daytime_active;
    } result_t;

endpackage

// ===== rtl/scrc_in_if.sv =====
`timescale 1ns / 1ps

interface scrc_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [4:0]        hour;
    logic signed [7:0] hot_zone_temp;
    logic signed [7:0] cold_zone_temp;
    logic signed [7:0] ambient_temp;
    logic              emergency_cut;

    modport source (
        output valid, month, day_of_month, hour, hot_zone_temp, cold_zone_temp,
               ambient_temp, emergency_cut,
        input  ready
    );
    modport sink (
        input  valid, month, day_of_month, hour, hot_zone_temp, cold_zone_temp,
               ambient_temp, emergency_cut,
        output ready
    );
endinterface

// ===== rtl/scrc_out_if.sv =====
`timescale 1ns / 1ps

interface scrc_out_if;
    logic valid;
    logic ready;
    logic heater_on;
    logic spot_on;
    logic uv_on;
    logic vent_on;
    logic winter_active;
    logic daytime_active;

    modport source (
        output valid, heater_on, spot_on, uv_on, vent_on, winter_active, daytime_active,
        input  ready
    );
    modport sink (
        input  valid, heater_on, spot_on, uv_on, vent_on, winter_active, daytime_active,
        output ready
    );
endinterface

// ===== rtl/scrc_cfg_if.sv =====
`timescale 1ns / 1ps

interface scrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [39:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/scrc_cfg_regs.sv =====
`timescale 1ns / 1ps

module scrc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    scrc_cfg_if.sink      cfg,
    output scrc_pkg::cfg_t regs
);
    import scrc_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.summer_day_limits   <= SUMMER_DAY_RST;
            regs_reg.summer_night_limits <= SUMMER_NIGHT_RST;
            regs_reg.winter_day_limits   <= WINTER_DAY_RST;
            regs_reg.winter_night_limits <= WINTER_NIGHT_RST;
            regs_reg.season_start_dates  <= SEASON_DATES_RST;
            regs_reg.day_night_hours     <= DAY_HOURS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SUMMER_DAY:   regs_reg.summer_day_limits   <= cfg.data;
                CFG_SUMMER_NIGHT: regs_reg.summer_night_limits <= cfg.data[15:0];
                CFG_WINTER_DAY:   regs_reg.winter_day_limits   <= cfg.data;
                CFG_WINTER_NIGHT: regs_reg.winter_night_limits <= cfg.data[15:0];
                CFG_SEASON_DATES: regs_reg.season_start_dates  <= cfg.data[17:0];
                CFG_DAY_HOURS:    regs_reg.day_night_hours     <= cfg.data[19:0];
                default:          ; // unused indexes are ignored
            endcase
        end
    end

endmodule

// ===== rtl/scrc_decide.sv =====
`timescale 1ns / 1ps

module scrc_decide (
    input  scrc_pkg::cfg_t    regs,
    input  scrc_pkg::sensor_t item,
    input  scrc_pkg::latch_t  cur,
    output scrc_pkg::latch_t  nxt,
    output scrc_pkg::result_t res
);
    import scrc_pkg::*;

    logic [4:0]        s_day;
    logic [3:0]        s_mon;
    logic [4:0]        w_day;
    logic [3:0]        w_mon;
    logic              winter;
    logic [39:0]       dayl;
    logic [15:0]       nightl;
    logic [4:0]        day_start;
    logic [4:0]        night_start;
    logic              daytime;
    logic              spot_window;
    logic signed [7:0] hot;
    logic signed [7:0] cold;
    logic signed [7:0] amb;
    logic signed [7:0] hot_min;
    logic signed [7:0] hot_max;
    logic signed [7:0] cold_max;
    logic signed [7:0] amb_min;
    logic signed [7:0] amb_max;
    logic signed [7:0] n_min;
    logic signed [7:0] n_max;
    latch_t            upd;

    always_comb
    begin
        s_day = regs.season_start_dates[4:0];
        s_mon = regs.season_start_dates[8:5];
        w_day = regs.season_start_dates[13:9];
        w_mon = regs.season_start_dates[17:14];

        winter = (item.month > w_mon) || (item.month < s_mon)
              || (item.month == w_mon && item.day_of_month >= w_day)
              || (item.month == s_mon && item.day_of_month < s_day);

        dayl        = winter ? regs.winter_day_limits : regs.summer_day_limits;
        nightl      = winter ? regs.winter_night_limits : regs.summer_night_limits;
        day_start   = winter ? regs.day_night_hours[14:10] : regs.day_night_hours[4:0];
        night_start = winter ? regs.day_night_hours[19:15] : regs.day_night_hours[9:5];
        daytime     = (day_start <= item.hour) && (item.hour < night_start);
        spot_window = (item.hour >= SPOT_FIRST_HOUR) && (item.hour <= SPOT_LAST_HOUR);

        hot      = $signed(item.hot_zone_temp);
        cold     = $signed(item.cold_zone_temp);
        amb      = $signed(item.ambient_temp);
        hot_min  = $signed(dayl[7:0]);
        hot_max  = $signed(dayl[15:8]);
        cold_max = $signed(dayl[23:16]);
        amb_min  = $signed(dayl[31:24]);
        amb_max  = $signed(dayl[39:32]);
        n_min    = $signed(nightl[7:0]);
        n_max    = $signed(nightl[15:8]);

        upd = cur;
        if (daytime)
        begin
            if (cold >= cold_max)
            begin
                upd = '{heater: 1'b0, spot: 1'b0, uv: 1'b0, vent: 1'b1};
            end
            else
            begin
                // off wins for heater and spot, on wins for UV
                if (hot <= hot_min) upd.heater = 1'b1;
                if (hot >= hot_max) upd.heater = 1'b0;
                if (amb >= amb_max) upd.uv = 1'b0;
                if (amb <= amb_min) upd.uv = 1'b1;
                upd.vent = (amb >= amb_max);
                if (spot_window)
                begin
                    if (amb <= amb_min) upd.spot = 1'b1;
                    if (amb >= amb_max) upd.spot = 1'b0;
                end
                else
                begin
                    upd.spot = (hot < hot_min);
                end
            end
        end
        else
        begin
            upd.spot = 1'b0;
            upd.uv   = 1'b0;
            upd.vent = 1'b0;
            if (hot <= n_min) upd.heater = 1'b1;
            if (hot >= n_max) upd.heater = 1'b0;
        end

        // emergency holds the latches and blanks the drives
        nxt                = item.emergency_cut ? cur : upd;
        res.heater_on      = !item.emergency_cut && upd.heater;
        res.spot_on        = !item.emergency_cut && upd.spot;
        res.uv_on          = !item.emergency_cut && upd.uv;
        res.vent_on        = !item.emergency_cut && upd.vent;
        res.winter_active  = winter;
        res.daytime_active = daytime;
    end

endmodule

// ===== rtl/seasonal_climate_relay_controller.sv =====
`timescale 1ns / 1ps

// Seasonal climate relay controller. Takes one sensor word per clock and
// returns one relay word per sensor word, in order. A word accepted on the
// sensor channel waits in the input register and moves into the result
// register when that register is empty or its word is being taken; the
// result register drives the relay channel. The block sustains one word per
// cycle as long as the relay sink keeps ready high. The relay latches are
// updated as a word moves from the input register into the result register,
// so each word sees the latches left by the one before it. The configuration
// channel is always ready; write it only when no word is in flight.
module seasonal_climate_relay_controller (
    input  logic        clk,
    input  logic        rst_n,
    scrc_in_if.sink     sensor,
    scrc_out_if.source  relay,
    scrc_cfg_if.sink    cfg
);
    import scrc_pkg::*;

    cfg_t    regs;
    sensor_t item_reg;
    logic    item_valid_reg;
    latch_t  latch_reg;
    latch_t  latch_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    take;

    scrc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    scrc_decide u_decide (
        .regs (regs),
        .item (item_reg),
        .cur  (latch_reg),
        .nxt  (latch_next),
        .res  (res_next)
    );

    assign advance      = !out_valid_reg || relay.ready;
    assign sensor.ready = !item_valid_reg || advance;
    assign take         = sensor.valid && sensor.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            latch_reg      <= '{heater: 1'b1, spot: 1'b1, uv: 1'b1, vent: 1'b1};
        end
        else
        begin
            if (sensor.ready)
            begin
                item_valid_reg <= sensor.valid;
            end
            if (advance)
            begin
                out_valid_reg <= item_valid_reg;
                if (item_valid_reg)
                begin
                    latch_reg <= latch_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.month          <= sensor.month;
            item_reg.day_of_month   <= sensor.day_of_month;
            item_reg.hour           <= sensor.hour;
            item_reg.hot_zone_temp  <= sensor.hot_zone_temp;
            item_reg.cold_zone_temp <= sensor.cold_zone_temp;
            item_reg.ambient_temp   <= sensor.ambient_temp;
            item_reg.emergency_cut  <= sensor.emergency_cut;
        end
        if (advance && item_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign relay.valid          = out_valid_reg;
    assign relay.heater_on      = res_reg.heater_on;
    assign relay.spot_on        = res_reg.spot_on;
    assign relay.uv_on          = res_reg.uv_on;
    assign relay.vent_on        = res_reg.vent_on;
    assign relay.winter_active  = res_reg.winter_active;
    assign relay.daytime_active = res_reg.daytime_active;

endmodule
